// ===== sv/polygon_area_perimeter_top_macros.svh =====
// Assertion macros used by the back stage (pap_back), which checks its own logic.
`ifndef POLYGON_AREA_PERIMETER_TOP_MACROS_SVH
`define POLYGON_AREA_PERIMETER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PAP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PAP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/pap_pkg.sv =====
`timescale 1ns / 1ps
package pap_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int COORD_W      = 16;
  localparam int CNT_W        = $clog2(MAX_VERTICES + 2);
  localparam int DIFF_W       = COORD_W + 1;
  localparam int MUL_W        = DIFF_W + 1;
  localparam int PROD_W       = 2 * MUL_W;
  localparam int CROSS_W      = 2 * DIFF_W + 1;
  localparam int MAG_W        = CROSS_W - 1;
  localparam int HALF_W       = MAG_W / 2;
  localparam int SUM_W        = 2 * MAG_W + 2;
  localparam int ROOT_W       = SUM_W / 2;
  localparam int REM_W        = ROOT_W + 3;
  localparam int NARROW_IT    = DIFF_W + 1;
  localparam int IT_W         = $clog2(ROOT_W + 1);
  localparam int AREA_W       = 48;
  localparam int PERIM_W      = 32;
  localparam int QDEPTH       = 2;
  localparam int QPTR_W       = $clog2(QDEPTH);
  localparam int QCNT_W       = $clog2(QDEPTH + 1);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic        [DIFF_W-1:0]  diff_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SHORT = 2'd1,
    ST_LONG  = 2'd2
  } status_t;

  // One queued job: which steps to run and the operands they need.
  typedef struct packed {
    logic             edge_en;
    logic             tri_en;
    logic             close_en;
    logic             last;
    status_t          status;
    logic [2:0][DIFF_W-1:0] ed;
    logic [2:0][DIFF_W-1:0] u;
    logic [2:0][DIFF_W-1:0] v;
    logic [2:0][DIFF_W-1:0] cd;
  } cmd_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_EDGE,
    BK_CROSS,
    BK_SQ,
    BK_CLOSE,
    BK_ROOT_GO,
    BK_ROOT_WAIT,
    BK_EMIT
  } bk_state_t;

  typedef enum logic [1:0] {
    RK_EDGE,
    RK_TRI,
    RK_CLOSE
  } rk_t;

  typedef enum logic [1:0] {
    SH_LO,
    SH_MID,
    SH_HI
  } shift_t;

  // Signed difference of two coordinates, one bit wider.
  function automatic diff_t coord_diff(coord_t a, coord_t b);
    return $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
  endfunction

  // Sign-extend a difference to a multiplier operand.
  function automatic logic signed [MUL_W-1:0] to_mul(diff_t d);
    return $signed({d[DIFF_W-1], d});
  endfunction

endpackage

// ===== sv/pap_front.sv =====
`timescale 1ns / 1ps
module pap_front
  import pap_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [47:0]  in_tdata,
  input  logic         in_tlast,
  input  logic         q_full,
  output logic         q_push,
  output cmd_t         q_cmd
);

  coord_t             first_r [3];
  coord_t             prev_r  [3];
  logic [CNT_W-1:0]   count_r;

  coord_t             cur [3];
  logic               accept;
  logic               in_range;
  logic [CNT_W-1:0]   count_after;

  assign cur[0] = in_tdata[COORD_W-1:0];
  assign cur[1] = in_tdata[2*COORD_W-1:COORD_W];
  assign cur[2] = in_tdata[3*COORD_W-1:2*COORD_W];

  assign in_tready   = !q_full;
  assign accept      = in_tvalid && in_tready;
  assign in_range    = count_r < CNT_W'(MAX_VERTICES);
  assign count_after = in_range ? count_r + 1'b1 : CNT_W'(MAX_VERTICES + 1);

  // Classify the vertex and build the job for the back end
  always_comb begin
    q_cmd.edge_en = in_range && (count_r >= CNT_W'(1));
    q_cmd.tri_en  = in_range && (count_r >= CNT_W'(2));
    q_cmd.last    = in_tlast;
    if (count_after > CNT_W'(MAX_VERTICES)) begin
      q_cmd.status = ST_LONG;
    end else if (count_after < CNT_W'(3)) begin
      q_cmd.status = ST_SHORT;
    end else begin
      q_cmd.status = ST_OK;
    end
    q_cmd.close_en = in_tlast && (q_cmd.status == ST_OK);
    for (int k = 0; k < 3; k++) begin
      q_cmd.ed[k] = coord_diff(cur[k], prev_r[k]);
      q_cmd.u[k]  = coord_diff(prev_r[k], first_r[k]);
      q_cmd.v[k]  = coord_diff(cur[k], first_r[k]);
      q_cmd.cd[k] = coord_diff(first_r[k], cur[k]);
    end
  end

  // Skip words that start nothing
  assign q_push = accept && (q_cmd.edge_en || q_cmd.tri_en || in_tlast);

  // Track first and previous vertex and the count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      for (int k = 0; k < 3; k++) begin
        first_r[k] <= '0;
        prev_r[k]  <= '0;
      end
    end else if (accept) begin
      if (in_tlast) begin
        count_r <= '0;
        for (int k = 0; k < 3; k++) begin
          first_r[k] <= '0;
          prev_r[k]  <= '0;
        end
      end else begin
        count_r <= count_after;
        if (in_range) begin
          for (int k = 0; k < 3; k++) begin
            prev_r[k] <= cur[k];
            if (count_r == '0) begin
              first_r[k] <= cur[k];
            end
          end
        end
      end
    end
  end

endmodule

// ===== sv/pap_fifo.sv =====
`timescale 1ns / 1ps
module pap_fifo
  import pap_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic full,
  output logic empty
);

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign full  = cnt_r == QCNT_W'(QDEPTH);
  assign empty = cnt_r == '0;
  assign head  = mem_r[rd_ptr_r];

  // Store incoming jobs
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

endmodule

// ===== sv/pap_sqrt.sv =====
`timescale 1ns / 1ps
module pap_sqrt
  import pap_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              narrow,
  input  logic [SUM_W-1:0]  radicand,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  logic [SUM_W-1:0]  rad_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [IT_W-1:0]   it_r;
  logic              busy_r;
  logic              done_r;

  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic              take;

  // One result bit per cycle: bring down two radicand bits, try root*4+1
  assign rem_sh = {rem_r[REM_W-3:0], rad_r[SUM_W-1:SUM_W-2]};
  assign trial  = REM_W'({root_r, 2'b01});
  assign take   = rem_sh >= trial;

  assign done = done_r;
  assign root = root_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      it_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        it_r   <= narrow ? IT_W'(NARROW_IT) : IT_W'(ROOT_W);
      end else if (busy_r) begin
        it_r <= it_r - 1'b1;
        if (it_r == IT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: align narrow radicands to the top, then iterate
  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= narrow ? radicand << (SUM_W - 2 * NARROW_IT) : radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= rad_r << 2;
      rem_r  <= take ? rem_sh - trial : rem_sh;
      root_r <= {root_r[ROOT_W-2:0], take};
    end
  end

endmodule

// ===== sv/pap_back.sv =====
`timescale 1ns / 1ps
`include "polygon_area_perimeter_top_macros.svh"
module pap_back
  import pap_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               head,
  input  logic               q_empty,
  output logic               q_pop,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [AREA_W-1:0]  out_area,
  output logic [PERIM_W-1:0] out_perim,
  output status_t            out_status
);

  bk_state_t state_r, state_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic [1:0] jc_r, jc_nxt;
  rk_t        rk_r, rk_nxt;
  cmd_t       cmd_r;

  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic        mul_go, mul_to_cross, mul_neg;
  shift_t      mul_sh;

  logic signed [PROD_W-1:0]  prod_r;
  logic        prod_vld_r, prod_cross_r, prod_neg_r;
  shift_t      prod_sh_r;

  logic signed [CROSS_W-1:0] acc_c_r;
  logic [SUM_W-1:0]          ssum_r;
  logic [AREA_W-1:0]         area_r;
  logic [PERIM_W-1:0]        perim_r;

  logic                      out_valid_r;
  logic [AREA_W-1:0]         out_area_r;
  logic [PERIM_W-1:0]        out_perim_r;
  status_t                   out_status_r;

  logic                      sq_start, sq_done;
  logic [ROOT_W-1:0]         sq_root;
  logic                      emit_go;

  logic [MAG_W-1:0]          mag;
  logic [1:0]                i1, i2;
  bk_state_t                 after_edge, after_tri, after_close, first_phase;
  logic signed [CROSS_W-1:0] cross_term;
  logic [SUM_W-1:0]          sum_term;
  logic [AREA_W:0]           area_add;
  logic [ROOT_W:0]           perim_add;

  pap_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .narrow   (rk_r != RK_TRI),
    .radicand (ssum_r),
    .done     (sq_done),
    .root     (sq_root)
  );

  // Magnitude of the finished cross component, and its operand pair
  assign mag = MAG_W'(acc_c_r[CROSS_W-1] ? -acc_c_r : acc_c_r);

  always_comb begin
    unique case (jc_r)
      2'd0:    begin i1 = 2'd1; i2 = 2'd2; end
      2'd1:    begin i1 = 2'd2; i2 = 2'd0; end
      default: begin i1 = 2'd0; i2 = 2'd1; end
    endcase
  end

  // Phase order within one job
  assign after_close = cmd_r.last ? BK_EMIT : BK_IDLE;
  assign after_tri   = cmd_r.close_en ? BK_CLOSE : after_close;
  assign after_edge  = cmd_r.tri_en ? BK_CROSS : after_tri;

  always_comb begin
    priority if (head.edge_en) first_phase = BK_EDGE;
    else if (head.tri_en)      first_phase = BK_CROSS;
    else if (head.close_en)    first_phase = BK_CLOSE;
    else if (head.last)        first_phase = BK_EMIT;
    else                       first_phase = BK_IDLE;
  end

  // Sequencer: feed the shared multiplier and the root unit
  always_comb begin
    state_nxt    = state_r;
    jc_nxt       = jc_r;
    rk_nxt       = rk_r;
    q_pop        = 1'b0;
    sq_start     = 1'b0;
    emit_go      = 1'b0;
    mul_go       = 1'b0;
    mul_a        = '0;
    mul_b        = '0;
    mul_to_cross = 1'b0;
    mul_neg      = 1'b0;
    mul_sh       = SH_LO;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          jc_nxt    = '0;
          state_nxt = first_phase;
        end
      end
      BK_EDGE, BK_CLOSE: begin
        if (cnt_r < 2'd3) begin
          mul_go = 1'b1;
          mul_a  = to_mul((state_r == BK_EDGE) ? cmd_r.ed[cnt_r] : cmd_r.cd[cnt_r]);
          mul_b  = mul_a;
        end else begin
          rk_nxt    = (state_r == BK_EDGE) ? RK_EDGE : RK_CLOSE;
          state_nxt = BK_ROOT_GO;
        end
      end
      BK_CROSS: begin
        if (cnt_r < 2'd2) begin
          mul_go       = 1'b1;
          mul_to_cross = 1'b1;
          mul_neg      = cnt_r[0];
          mul_a        = to_mul(cnt_r[0] ? cmd_r.u[i2] : cmd_r.u[i1]);
          mul_b        = to_mul(cnt_r[0] ? cmd_r.v[i1] : cmd_r.v[i2]);
        end else begin
          state_nxt = BK_SQ;
        end
      end
      BK_SQ: begin
        if (cnt_r < 2'd3) begin
          mul_go = 1'b1;
          unique case (cnt_r)
            2'd0: begin
              mul_a = $signed({1'b0, mag[HALF_W-1:0]});
              mul_b = mul_a;
            end
            2'd1: begin
              mul_a  = $signed({1'b0, mag[MAG_W-1:HALF_W]});
              mul_b  = $signed({1'b0, mag[HALF_W-1:0]});
              mul_sh = SH_MID;
            end
            default: begin
              mul_a  = $signed({1'b0, mag[MAG_W-1:HALF_W]});
              mul_b  = mul_a;
              mul_sh = SH_HI;
            end
          endcase
        end else if (jc_r == 2'd2) begin
          rk_nxt    = RK_TRI;
          state_nxt = BK_ROOT_GO;
        end else begin
          jc_nxt    = jc_r + 1'b1;
          state_nxt = BK_CROSS;
        end
      end
      BK_ROOT_GO: begin
        sq_start  = 1'b1;
        state_nxt = BK_ROOT_WAIT;
      end
      BK_ROOT_WAIT: begin
        if (sq_done) begin
          unique case (rk_r)
            RK_EDGE: state_nxt = after_edge;
            RK_TRI:  state_nxt = after_tri;
            default: state_nxt = after_close;
          endcase
        end
      end
      BK_EMIT: begin
        if (!out_valid_r || out_tready) begin
          emit_go   = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
    cnt_nxt = (state_nxt != state_r) ? 2'd0 : cnt_r + 1'b1;
  end

  // Accumulate terms from the product register
  assign cross_term = prod_neg_r ? -$signed(prod_r[CROSS_W-1:0])
                                 : $signed(prod_r[CROSS_W-1:0]);
  always_comb begin
    unique case (prod_sh_r)
      SH_MID:  sum_term = SUM_W'(prod_r[PROD_W-2:0]) << (HALF_W + 1);
      SH_HI:   sum_term = SUM_W'(prod_r[PROD_W-2:0]) << (2 * HALF_W);
      default: sum_term = SUM_W'(prod_r[PROD_W-2:0]);
    endcase
  end

  assign area_add  = {1'b0, area_r} + (AREA_W + 1)'(sq_root >> 1);
  assign perim_add = (ROOT_W + 1)'(perim_r) + (ROOT_W + 1)'(sq_root);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      cnt_r       <= '0;
      jc_r        <= '0;
      rk_r        <= RK_EDGE;
      prod_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
      area_r      <= '0;
      perim_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      jc_r       <= jc_nxt;
      rk_r       <= rk_nxt;
      prod_vld_r <= mul_go;
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      // Add roots into the sums, saturating; clear after a result
      if (emit_go) begin
        area_r  <= '0;
        perim_r <= '0;
      end else if (sq_done) begin
        if (rk_r == RK_TRI) begin
          area_r <= area_add[AREA_W] ? '1 : area_add[AREA_W-1:0];
        end else begin
          perim_r <= (perim_add > (ROOT_W + 1)'({PERIM_W{1'b1}}))
                     ? '1 : perim_add[PERIM_W-1:0];
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= head;
    end
    prod_r       <= mul_a * mul_b;
    prod_cross_r <= mul_to_cross;
    prod_neg_r   <= mul_neg;
    prod_sh_r    <= mul_sh;
    if (state_nxt == BK_CROSS && state_r != BK_CROSS) begin
      acc_c_r <= '0;
    end else if (prod_vld_r && prod_cross_r) begin
      acc_c_r <= acc_c_r + cross_term;
    end
    // Start the square sum from zero after reset and after each root launch
    if (!rst_n || sq_start) begin
      ssum_r <= '0;
    end else if (prod_vld_r && !prod_cross_r) begin
      ssum_r <= ssum_r + sum_term;
    end
    if (emit_go) begin
      out_status_r <= cmd_r.status;
      unique case (cmd_r.status)
        ST_LONG: begin
          out_area_r  <= '1;
          out_perim_r <= '1;
        end
        ST_SHORT: begin
          out_area_r  <= '0;
          out_perim_r <= '0;
        end
        default: begin
          out_area_r  <= area_r;
          out_perim_r <= perim_r;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_area   = out_area_r;
  assign out_perim  = out_perim_r;
  assign out_status = out_status_r;

  `PAP_ASSERT_NOW(a_done_in_wait, sq_done, state_r == BK_ROOT_WAIT, "root done outside wait")
  `PAP_ASSERT_NOW(a_pop_in_idle, q_pop, state_r == BK_IDLE && !q_empty, "pop outside idle")
  `PAP_ASSERT_NEXT(a_emit_loads, emit_go, out_valid_r, "result not loaded")

endmodule

// ===== sv/polygon_area_perimeter_top.sv =====
`timescale 1ns / 1ps
// Polygon area and perimeter of a planar convex polygon in 3D.
// Input stream: one vertex per word, in boundary order; tdata carries x, y, z
// (signed Q8.8) and tlast marks the final vertex of the polygon.
// Output stream: one word per polygon on its final vertex; tdata carries the
// area (16 fraction bits) and the perimeter (8 fraction bits), tuser the status
// (ok, fewer than three vertices, too many vertices).
// A front stage classifies each vertex and queues a job (two deep); a back
// stage works the job on one shared 18x18 multiplier and a root unit that
// makes one result bit per cycle.
// Work per vertex: the second vertex needs the root of its edge, and each
// vertex from the third on needs an 18-bit edge root plus a 35-bit area
// root; the final vertex adds the root for the closing edge.
// The polygon's result is then loaded into the output register.
// Reset clears the stored vertices, count, sums, queue and output valid flag.
// When the receiver stalls, the result holds in its output register, the back
// stage waits on its next result, and in_tready falls once the queue fills.
module polygon_area_perimeter_top
  import pap_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // vertex_x[15:0], vertex_y[31:16], vertex_z[47:32]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // area[47:0], perimeter[79:48]
  output logic [1:0]  out_tuser   // status[1:0]
);

  logic    q_full, q_empty, q_push, q_pop;
  cmd_t    q_cmd, q_head;
  logic [AREA_W-1:0]  area;
  logic [PERIM_W-1:0] perimeter;
  status_t status;

  pap_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_cmd)
  );

  pap_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  pap_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_area   (area),
    .out_perim  (perimeter),
    .out_status (status)
  );

  assign out_tdata = {perimeter, area};
  assign out_tuser = status;

endmodule
